/* hw/rtl/rtpl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpl_pkg
// Shared widths, constants, types and helpers of the resonant two-pole lowpass.
// ----------------------------------------------------------------------------
package rtpl_pkg;

   localparam int CHANNELS = 8;

   localparam int SMP_W   = 24;
   localparam int CH_W    = 3;
   localparam int ST_W    = 26;
   localparam int COEF_W  = 17;
   localparam int GAIN_W  = 16;
   localparam int IDX_W   = 8;
   localparam int DATA_W  = 17;
   localparam int DIFF_W  = ST_W + 1;
   localparam int MB_W    = COEF_W + 1;
   localparam int PROD_W  = DIFF_W + MB_W;
   localparam int ACC_W   = PROD_W + 1;

   localparam logic [IDX_W-1:0] REG_CUTOFF_COEF    = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_RESONANCE_GAIN = IDX_W'(1);

   localparam logic [COEF_W-1:0] COEF_ONE       = COEF_W'(65536);
   localparam logic [COEF_W-1:0] COEF_RESET     = COEF_W'(32768);
   localparam logic [GAIN_W-1:0] GAIN_RESET     = '0;
   localparam logic signed [ST_W-1:0] FIRST_RESET  = ST_W'(12583);
   localparam logic signed [ST_W-1:0] SECOND_RESET = -ST_W'(5620);

   localparam logic signed [ACC_W-1:0] RND_FB   = ACC_W'(2048);
   localparam logic signed [ACC_W-1:0] RND_POLE = ACC_W'(32768);
   localparam int FB_SHIFT   = 12;
   localparam int POLE_SHIFT = 16;

   localparam logic signed [ACC_W-1:0] SMP_MAX_WIDE =
      {{(ACC_W-SMP_W+1){1'b0}}, {(SMP_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SMP_MIN_WIDE =
      {{(ACC_W-SMP_W+1){1'b1}}, {(SMP_W-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_FB,
      OP_SUM,
      OP_MUL1,
      OP_LP1,
      OP_MUL2,
      OP_LP2
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   function automatic logic signed [SMP_W-1:0] clamp_sample(
      input logic signed [ACC_W-1:0] v);
      logic signed [SMP_W-1:0] r;
      if (v > SMP_MAX_WIDE) begin
         r = SMP_MAX_WIDE[SMP_W-1:0];
      end else if (v < SMP_MIN_WIDE) begin
         r = SMP_MIN_WIDE[SMP_W-1:0];
      end else begin
         r = v[SMP_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/rtpl_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpl_req_if
// Input sample channel: one audio sample tagged with its channel per item.
// ----------------------------------------------------------------------------
interface rtpl_req_if import rtpl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SMP_W-1:0] sample_in;
   logic [CH_W-1:0]         channel_in;

   modport source (output valid, output sample_in, output channel_in, input ready);
   modport sink (input valid, input sample_in, input channel_in, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rtpl_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpl_rsp_if
// Result channel: one filtered sample and its channel per item.
// ----------------------------------------------------------------------------
interface rtpl_rsp_if import rtpl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SMP_W-1:0] sample_out;
   logic [CH_W-1:0]         channel_out;

   modport source (output valid, output sample_out, output channel_out, input ready);
   modport sink (input valid, input sample_out, input channel_out, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rtpl_csr_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpl_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rtpl_csr_if import rtpl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  index;
   logic [DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rtpl_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpl_ctrl
// Sequencer that steps the datapath through one sample and owns the handshakes.
// ----------------------------------------------------------------------------
module rtpl_ctrl import rtpl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_FB,
      ST_SUM,
      ST_MUL1,
      ST_LP1,
      ST_MUL2,
      ST_LP2
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_MUL_FB;
            end
         end
         ST_MUL_FB: begin
            cmd.op   = OP_MUL_FB;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.op   = OP_MUL1;
            state_in = ST_LP1;
         end
         ST_LP1: begin
            cmd.op   = OP_LP1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.op   = OP_MUL2;
            state_in = ST_LP2;
         end
         ST_LP2: begin
            if (out_free) begin
               cmd.op       = OP_LP2;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/rtpl_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpl_dp
// Datapath: per-channel filter state, registers, one shared multiplier.
// ----------------------------------------------------------------------------
module rtpl_dp import rtpl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   input  logic signed [SMP_W-1:0] sample_in,
   input  logic [CH_W-1:0]         channel_in,
   input  logic                    csr_write,
   input  logic [IDX_W-1:0]        csr_index,
   input  logic [DATA_W-1:0]       csr_data,
   output logic signed [SMP_W-1:0] sample_out,
   output logic [CH_W-1:0]         channel_out
);

   logic [COEF_W-1:0]        cutoff_ff;
   logic [GAIN_W-1:0]        gain_ff;

   logic signed [ST_W-1:0]   first_mem_ff  [CHANNELS];
   logic signed [ST_W-1:0]   second_mem_ff [CHANNELS];
   logic signed [ST_W-1:0]   fb_mem_ff     [CHANNELS];

   logic signed [SMP_W-1:0]  x_ff;
   logic [CH_W-1:0]          ch_ff;
   logic                     bypass_ff;
   logic signed [MB_W-1:0]   c_ff;
   logic signed [ST_W-1:0]   first_ff;
   logic signed [ST_W-1:0]   second_ff;
   logic signed [ST_W-1:0]   fb_ff;
   logic signed [ST_W-1:0]   acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SMP_W-1:0]  sample_out_ff;
   logic [CH_W-1:0]          channel_out_ff;

   logic signed [DIFF_W-1:0] mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [ACC_W-1:0]  prod_wide;
   logic signed [ACC_W-1:0]  fb_round;
   logic signed [ACC_W-1:0]  sum_wide;
   logic signed [ACC_W-1:0]  pole_base;
   logic signed [ACC_W-1:0]  pole_wide;
   logic signed [ST_W-1:0]   pole_out;
   logic [COEF_W-1:0]        c_eff;

   assign sample_out  = sample_out_ff;
   assign channel_out = channel_out_ff;

   assign c_eff = (cutoff_ff > COEF_ONE) ? COEF_ONE : cutoff_ff;

   always_comb begin
      case (cmd.op)
         OP_MUL_FB: begin
            mul_a = DIFF_W'(fb_ff);
            mul_b = $signed({{(MB_W-GAIN_W){1'b0}}, gain_ff});
         end
         OP_MUL1: begin
            mul_a = DIFF_W'(acc_ff) - DIFF_W'(first_ff);
            mul_b = c_ff;
         end
         default: begin
            mul_a = DIFF_W'(acc_ff) - DIFF_W'(second_ff);
            mul_b = c_ff;
         end
      endcase
   end

   assign prod_in   = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_wide = ACC_W'(prod_ff);
   assign fb_round  = (prod_wide + RND_FB) >>> FB_SHIFT;
   assign sum_wide  = ACC_W'(x_ff) + fb_round;

   always_comb begin
      if (cmd.op == OP_LP1) begin
         pole_base = ACC_W'(first_ff) <<< POLE_SHIFT;
      end else begin
         pole_base = ACC_W'(second_ff) <<< POLE_SHIFT;
      end
      pole_wide = (pole_base + prod_wide + RND_POLE) >>> POLE_SHIFT;
      pole_out  = pole_wide[ST_W-1:0];
      if (cmd.op == OP_SUM) begin
         acc_in = ST_W'(clamp_sample(sum_wide));
      end else begin
         acc_in = pole_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= COEF_RESET;
         gain_ff   <= GAIN_RESET;
      end else if (csr_write) begin
         if (csr_index == REG_CUTOFF_COEF) begin
            cutoff_ff <= csr_data[COEF_W-1:0];
         end else if (csr_index == REG_RESONANCE_GAIN) begin
            gain_ff <= csr_data[GAIN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CHANNELS; k++) begin
            first_mem_ff[k]  <= FIRST_RESET;
            second_mem_ff[k] <= SECOND_RESET;
            fb_mem_ff[k]     <= '0;
         end
      end else if (cmd.op == OP_LP2 && !bypass_ff) begin
         first_mem_ff[ch_ff]  <= acc_ff;
         second_mem_ff[ch_ff] <= pole_out;
         fb_mem_ff[ch_ff]     <= acc_ff - pole_out;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            x_ff      <= sample_in;
            ch_ff     <= channel_in;
            bypass_ff <= (32'(channel_in) >= 32'(CHANNELS));
            c_ff      <= $signed({1'b0, c_eff});
            first_ff  <= first_mem_ff[channel_in];
            second_ff <= second_mem_ff[channel_in];
            fb_ff     <= fb_mem_ff[channel_in];
         end
         OP_MUL_FB, OP_MUL1, OP_MUL2: begin
            prod_ff <= prod_in;
         end
         OP_SUM, OP_LP1: begin
            acc_ff <= acc_in;
         end
         OP_LP2: begin
            channel_out_ff <= ch_ff;
            if (bypass_ff) begin
               sample_out_ff <= x_ff;
            end else begin
               sample_out_ff <= clamp_sample(ACC_W'(pole_out));
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

/* hw/rtl/resonant_two_pole_lowpass.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// resonant_two_pole_lowpass
// Resonant two-pole lowpass filter with per-channel state for eight channels.
// ----------------------------------------------------------------------------
// The req_bus channel takes one Q1.23 sample tagged with a channel index per
// item; the rsp_bus channel returns the filtered sample and the same channel.
// The csr_bus channel writes cutoff_coef (index 0) and resonance_gain
// (index 1); it is always ready and other indexes are ignored.
// Each item runs through a six-step sequence on one shared multiplier: the
// feedback product, the clamped sum, and a product and a rounding step for
// each of the two one-pole stages. A result is presented once the last step
// has run, and no new item is taken until the previous item has finished
// that sequence.
// The result sits in an output register, so the next item is accepted while
// a result still waits. If the receiver stalls, the following item holds in
// its last step until the output register frees up, and no new item is taken.
// Reset clears the handshakes, restores the register defaults and loads the
// start values of every channel's filter state in the same cycle.
// ----------------------------------------------------------------------------
module resonant_two_pole_lowpass import rtpl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rtpl_req_if.sink   req_bus,
   rtpl_rsp_if.source rsp_bus,
   rtpl_csr_if.sink   csr_bus
);

   cmd_type cmd;

   assign csr_bus.ready = 1'b1;

   rtpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   rtpl_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sample_in   (req_bus.sample_in),
      .channel_in  (req_bus.channel_in),
      .csr_write   (csr_bus.valid),
      .csr_index   (csr_bus.index),
      .csr_data    (csr_bus.data),
      .sample_out  (rsp_bus.sample_out),
      .channel_out (rsp_bus.channel_out)
   );

endmodule
`default_nettype wire
